### rtl/rdbm_pkg.sv
`timescale 1ns / 1ps

package rdbm_pkg;

	// Default storage size in bytes.
	localparam int unsigned RamBytesDefault = 65536;

	// Byte lanes of one access, which is also the number of RAM banks.
	localparam int unsigned NumLanes = 4;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MAIN_BASE      = 3'd0,
		REG_MAIN_LIMIT     = 3'd1,
		REG_VIDEO_START    = 3'd2,
		REG_VIDEO_END      = 3'd3,
		REG_RESERVED_START = 3'd4,
		REG_RESERVED_END   = 3'd5,
		REG_IO_START       = 3'd6,
		REG_IO_END         = 3'd7
	} cfg_reg_t;

	// Request type and access size codes.
	localparam logic       REQ_READ  = 1'b0;
	localparam logic       REQ_WRITE = 1'b1;
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	// Reset values of the decoder registers that shape the behavior.
	localparam logic [31:0] MainStartReset  = 32'd0;
	localparam logic [31:0] MainEndReset    = 32'd49151;
	localparam logic [31:0] VideoStartReset = 32'd49152;
	localparam logic [31:0] VideoEndReset   = 32'd65535;
	localparam logic [31:0] IoEndReset      = 32'd655359;

	// Decoder window bounds, all inclusive.
	typedef struct packed {
		logic [31:0] main_base;
		logic [31:0] main_limit;
		logic [31:0] video_start;
		logic [31:0] video_end;
		logic [31:0] io_end;
	} cfg_t;

	// What the output side needs to reassemble one read result.
	typedef struct packed {
		logic [1:0]          off;
		logic [NumLanes-1:0] lane_ok;
		logic                flag;
	} lane_meta_t;

endpackage

### rtl/rdbm_ram.sv
`timescale 1ns / 1ps

module rdbm_ram #(
	parameter int unsigned WIDTH  = 8,
	parameter int unsigned DEPTH  = 16384,
	parameter int unsigned ADDR_W = 14
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data is registered and holds until the next read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### rtl/rdbm_clear.sv
`timescale 1ns / 1ps

module rdbm_clear #(
	parameter int unsigned DEPTH  = 16384,
	parameter int unsigned ADDR_W = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	output logic              active,
	output logic [ADDR_W-1:0] row
);

	logic              active_q;
	logic [ADDR_W-1:0] row_q;

	// Sweeps every row once after reset, then stays idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			row_q    <= '0;
		end else if (active_q) begin
			if (row_q == ADDR_W'(DEPTH - 1)) begin
				active_q <= 1'b0;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	assign active = active_q;
	assign row    = row_q;

endmodule

### rtl/rdbm_decode.sv
`timescale 1ns / 1ps

module rdbm_decode
	import rdbm_pkg::*;
#(
	parameter int unsigned RAM_BYTES = RamBytesDefault,
	parameter int unsigned ROW_W     = 14
) (
	input  logic              req_type,
	input  logic [1:0]        access_size,
	input  logic [31:0]       address,
	input  logic [31:0]       write_data,
	input  cfg_t              cfg,
	output logic [NumLanes-1:0] bank_we,
	output logic [NumLanes-1:0] bank_re,
	output logic [ROW_W-1:0]  bank_row   [NumLanes],
	output logic [7:0]        bank_wdata [NumLanes],
	output lane_meta_t        meta
);

	localparam logic [32:0] RamLimit = 33'(RAM_BYTES);

	logic [31:0]         byte_addr [NumLanes];
	logic [1:0]          lane_of   [NumLanes];
	logic [NumLanes-1:0] used;
	logic [NumLanes-1:0] backed;
	logic [2:0]          nbytes;
	logic                is_read;
	logic                flag;

	// Per-byte address and decode.
	always_comb begin
		case (access_size)
			SIZE_BYTE: nbytes = 3'd1;
			SIZE_HALF: nbytes = 3'd2;
			default:   nbytes = 3'd4;
		endcase
		is_read = (req_type == REQ_READ);
		for (int i = 0; i < NumLanes; i++) begin
			byte_addr[i] = address + 32'(i);
			used[i]      = (3'(i) < nbytes);
			backed[i]    = (byte_addr[i] <= cfg.io_end) &&
				(((byte_addr[i] >= cfg.main_base) && (byte_addr[i] <= cfg.main_limit)) ||
				 ((byte_addr[i] >= cfg.video_start) && (byte_addr[i] <= cfg.video_end))) &&
				({1'b0, byte_addr[i]} < RamLimit);
		end
		// A word read whose wrapped last byte is past storage returns zero.
		flag = is_read && (nbytes == 3'd4) && ({1'b0, byte_addr[NumLanes-1]} >= RamLimit);
	end

	// Bank b serves the byte whose address has b in its low two bits.
	always_comb begin
		for (int b = 0; b < NumLanes; b++) begin
			lane_of[b]    = 2'(b) - address[1:0];
			bank_row[b]   = byte_addr[lane_of[b]][ROW_W+1:2];
			bank_we[b]    = !is_read && used[lane_of[b]] && backed[lane_of[b]];
			bank_re[b]    = is_read && !flag && used[lane_of[b]] && backed[lane_of[b]];
			bank_wdata[b] = write_data[8*lane_of[b] +: 8];
		end
		meta.off  = address[1:0];
		meta.flag = flag;
		for (int i = 0; i < NumLanes; i++) begin
			meta.lane_ok[i] = is_read && !flag && used[i] && backed[i];
		end
	end

endmodule

### rtl/region_decoded_byte_memory.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     req_type, access_size, address, write_data
// out       output     out_valid / out_ready   read_data, word_out_of_bounds
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// One transaction enters per cycle while in_ready is high; its result is valid in the cycle after
// acceptance, since the four byte-wide RAM banks register their read data.
// A waiting result holds in the bank read registers; a new transaction is taken
// in the cycle the old result leaves.
// After reset the banks are cleared one row per cycle, across all (RAM_BYTES + 3) / 4 rows,
// with in_ready low; configuration writes are taken throughout.

module region_decoded_byte_memory
	import rdbm_pkg::*;
#(
	parameter int unsigned RAM_BYTES = RamBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [1:0]  access_size,
	input  logic [31:0] address,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        word_out_of_bounds,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Storage is split into four byte banks by the low two address bits, so any
	// aligned or unaligned access touches each bank at most once.
	localparam int unsigned RowDepth = (RAM_BYTES + 3) / 4;
	localparam int unsigned RowW     = (RowDepth > 1) ? $clog2(RowDepth) : 1;

	cfg_t                cfg_q;
	logic                out_valid_q;
	lane_meta_t          meta_q;

	logic [NumLanes-1:0] dec_we;
	logic [NumLanes-1:0] dec_re;
	logic [RowW-1:0]     dec_row   [NumLanes];
	logic [7:0]          dec_wdata [NumLanes];
	lane_meta_t          dec_meta;

	logic                clr_active;
	logic [RowW-1:0]     clr_row;

	logic                in_accept;
	logic                out_accept;

	logic [NumLanes-1:0] ram_en;
	logic [NumLanes-1:0] ram_we;
	logic [RowW-1:0]     ram_addr  [NumLanes];
	logic [7:0]          ram_wdata [NumLanes];
	logic [7:0]          ram_rdata [NumLanes];

	// Configuration registers. The reserved and peripheral window bounds have no
	// effect on the data path: those windows read zero and ignore writes just like
	// unmapped space, so only the backed windows and the upper limit are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.main_base   <= MainStartReset;
			cfg_q.main_limit  <= MainEndReset;
			cfg_q.video_start <= VideoStartReset;
			cfg_q.video_end   <= VideoEndReset;
			cfg_q.io_end      <= IoEndReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAIN_BASE:   cfg_q.main_base   <= cfg_data;
				REG_MAIN_LIMIT:  cfg_q.main_limit  <= cfg_data;
				REG_VIDEO_START: cfg_q.video_start <= cfg_data;
				REG_VIDEO_END:   cfg_q.video_end   <= cfg_data;
				REG_IO_END:      cfg_q.io_end      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Address decode: per-bank row, enables and write byte.
	rdbm_decode #(
		.RAM_BYTES (RAM_BYTES),
		.ROW_W     (RowW)
	) u_decode (
		.req_type    (req_type),
		.access_size (access_size),
		.address     (address),
		.write_data  (write_data),
		.cfg         (cfg_q),
		.bank_we     (dec_we),
		.bank_re     (dec_re),
		.bank_row    (dec_row),
		.bank_wdata  (dec_wdata),
		.meta        (dec_meta)
	);

	// Post-reset clearing sweep.
	rdbm_clear #(
		.DEPTH  (RowDepth),
		.ADDR_W (RowW)
	) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.active (clr_active),
		.row    (clr_row)
	);

	// The bank read registers act as the output buffer, so a new transaction may
	// enter only when the output is empty or is being taken in this cycle.
	assign in_ready   = !clr_active && (!out_valid_q || out_ready);
	assign in_accept  = in_valid && in_ready;
	assign out_accept = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (out_accept) begin
			out_valid_q <= 1'b0;
		end
	end

	// Lane map for the pending result.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			meta_q <= dec_meta;
		end
	end

	// Bank port selection: the clearing sweep writes zeros, otherwise the
	// accepted transaction drives each bank.
	always_comb begin
		for (int b = 0; b < NumLanes; b++) begin
			if (clr_active) begin
				ram_en[b]    = 1'b1;
				ram_we[b]    = 1'b1;
				ram_addr[b]  = clr_row;
				ram_wdata[b] = 8'h00;
			end else begin
				ram_en[b]    = in_accept && (dec_we[b] || dec_re[b]);
				ram_we[b]    = dec_we[b];
				ram_addr[b]  = dec_row[b];
				ram_wdata[b] = dec_wdata[b];
			end
		end
	end

	for (genvar b = 0; b < NumLanes; b++) begin : g_bank
		rdbm_ram #(
			.WIDTH  (8),
			.DEPTH  (RowDepth),
			.ADDR_W (RowW)
		) u_ram (
			.clk   (clk),
			.en    (ram_en[b]),
			.we    (ram_we[b]),
			.addr  (ram_addr[b]),
			.wdata (ram_wdata[b]),
			.rdata (ram_rdata[b])
		);
	end

	// Result byte i comes from the bank that held address + i. Bytes that were
	// not read, and every byte of a write or flagged read, are zero.
	always_comb begin
		for (int i = 0; i < NumLanes; i++) begin
			read_data[8*i +: 8] = meta_q.lane_ok[i] ? ram_rdata[2'(i) + meta_q.off] : 8'h00;
		end
	end

	assign out_valid          = out_valid_q;
	assign word_out_of_bounds = meta_q.flag;

endmodule
